// ----- design/assert_macros.svh -----
// Assertion macros shared by the mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication check, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ----- design/lcbm_pkg.sv -----
// Shared types, codes and constants of the cartridge bank mapper.
package lcbm_pkg;

    localparam int BANK_W            = 9;
    localparam int ADDR_W            = 16;
    localparam int TGT_W             = 23;
    localparam int COUNT_W           = 10;
    localparam int RED_STEPS         = 3;
    localparam int RED_BITS          = 3;
    localparam int MAX_ROM_BANKS_DEF = 512;

    typedef enum logic [1:0] {
        OP_CART_RD,
        OP_CART_WR,
        OP_HIGH_RD,
        OP_HIGH_WR
    } op_t;

    typedef enum logic [1:0] {
        LOCK_FIRST,
        LOCK_SECOND,
        LOCK_OPEN
    } lock_t;

    typedef enum logic [2:0] {
        KIND_ROM,
        KIND_RAM_RD,
        KIND_RAM_WR,
        KIND_OPEN_BUS,
        KIND_PASS,
        KIND_NONE
    } kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_RED_LOW,
        BK_RED_HIGH,
        BK_DONE
    } bk_state_t;

    // Address regions, bits 15:13 of the bus address
    localparam logic [2:0] RGN_0000 = 3'd0;
    localparam logic [2:0] RGN_2000 = 3'd1;
    localparam logic [2:0] RGN_4000 = 3'd2;
    localparam logic [2:0] RGN_6000 = 3'd3;
    localparam logic [2:0] RGN_A000 = 3'd5;
    localparam logic [2:0] RGN_C000 = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] REG_ROM_BANK_COUNT    = 3'd0;
    localparam logic [2:0] REG_RAM_BYTES         = 3'd1;
    localparam logic [2:0] REG_SCRAMBLED_HEADER  = 3'd2;
    localparam logic [2:0] REG_ALTERNATE_WIRING  = 3'd3;
    localparam logic [2:0] REG_BOOT_ROM_AT_START = 3'd4;

    localparam logic [15:0] HDR_READ_MASK  = 16'h8700;
    localparam logic [15:0] HDR_READ_MATCH = 16'h0100;
    localparam logic [15:0] HDR_WIN_MASK   = 16'hFF00;
    localparam logic [15:0] UNSCR_KEEP     = 16'hFFAC;
    localparam logic [15:0] SECOND_BIT     = 16'h0080;
    localparam logic [15:0] OUTER_SEL      = 16'h00C0;
    localparam logic [5:0]  LOCK_STEP_CNT  = 6'h31;
    localparam logic [7:0]  CTRL_OPEN_BITS = 8'h30;

    typedef struct packed {
        op_t         op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        boot_on;
        logic [2:0]  region;
        logic        hdr_read;
        logic        hdr_window;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [22:0] target;
        logic [7:0]  data;
    } result_t;

    typedef struct packed {
        logic [9:0]  rom_bank_count;
        logic [17:0] ram_bytes;
        logic        scrambled_header;
        logic        alternate_wiring;
    } cfg_t;

endpackage

// ----- design/lcbm_front.sv -----
// Front end: accepts and classifies bus accesses into a two-entry queue.
module lcbm_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           opcode,
    input  logic [15:0]          mem_address,
    input  logic [7:0]           write_data,
    input  logic                 boot_register_on,
    output logic                 q_valid,
    output lcbm_pkg::item_t      q_item,
    input  logic                 q_pop
);

    lcbm_pkg::item_t q_mem [2];
    lcbm_pkg::item_t cls;
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;

    // Classify the incoming item
    always_comb
    begin
        cls.op         = lcbm_pkg::op_t'(opcode);
        cls.addr       = mem_address;
        cls.data       = write_data;
        cls.boot_on    = boot_register_on;
        cls.region     = mem_address[15:13];
        cls.hdr_read   = (mem_address & lcbm_pkg::HDR_READ_MASK) == lcbm_pkg::HDR_READ_MATCH;
        cls.hdr_window = (mem_address & lcbm_pkg::HDR_WIN_MASK) == lcbm_pkg::HDR_READ_MATCH;
    end

    assign in_ready = count_reg != 2'd2;
    assign push     = in_valid && in_ready;
    assign q_valid  = count_reg != 2'd0;
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

    // Advance the queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

// ----- design/lcbm_mod.sv -----
// Iterative remainder unit that reduces a bank number by the bank count.
module lcbm_mod
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lcbm_pkg::BANK_W-1:0]   value,
    input  logic [lcbm_pkg::COUNT_W-1:0]  divisor,
    output logic                          done,
    output logic [lcbm_pkg::BANK_W-1:0]   result
);

    logic [lcbm_pkg::BANK_W-1:0]  num_reg;
    logic [lcbm_pkg::BANK_W-1:0]  num_next;
    logic [lcbm_pkg::COUNT_W-1:0] rem_reg;
    logic [lcbm_pkg::COUNT_W-1:0] rem_next;
    logic [1:0]                   cnt_reg;

    // Three restoring steps per cycle
    always_comb
    begin
        logic [lcbm_pkg::COUNT_W:0]  t;
        logic [lcbm_pkg::BANK_W-1:0] n;
        logic [lcbm_pkg::COUNT_W-1:0] r;
        n = num_reg;
        r = rem_reg;
        for (int j = 0; j < lcbm_pkg::RED_BITS; j++)
        begin
            t = {r, n[lcbm_pkg::BANK_W-1]};
            n = {n[lcbm_pkg::BANK_W-2:0], 1'b0};
            if (t >= {1'b0, divisor})
            begin
                t = t - {1'b0, divisor};
            end
            r = t[lcbm_pkg::COUNT_W-1:0];
        end
        num_next = n;
        rem_next = r;
    end

    assign done   = cnt_reg == 2'd0;
    assign result = (divisor == '0) ? '0 : rem_reg[lcbm_pkg::BANK_W-1:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= value;
            rem_reg <= '0;
        end
        else if (cnt_reg != 2'd0)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    // Count down the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (start)
        begin
            cnt_reg <= 2'(lcbm_pkg::RED_STEPS);
        end
        else if (cnt_reg != 2'd0)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

// ----- design/lcbm_back.sv -----
// Back end: executes queued accesses, keeps lock and bank state, drives results.
module lcbm_back
#(
    parameter int MAX_ROM_BANKS = lcbm_pkg::MAX_ROM_BANKS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lcbm_pkg::cfg_t              cfg,
    input  logic                        q_valid,
    input  lcbm_pkg::item_t             q_item,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output lcbm_pkg::result_t           out_res,
    output logic [lcbm_pkg::BANK_W-1:0] low_now,
    output logic [lcbm_pkg::BANK_W-1:0] high_now
);

    localparam logic [lcbm_pkg::COUNT_W-1:0] MaxBanks = lcbm_pkg::COUNT_W'(MAX_ROM_BANKS);

    lcbm_pkg::bk_state_t state_reg, state_next;
    lcbm_pkg::item_t     cur_reg;
    lcbm_pkg::lock_t     lock_reg, lock_next;
    logic [5:0]          hcnt_reg, hcnt_next;
    logic [7:0]          mask_reg, mask_next;
    logic [7:0]          unm_reg, unm_next;
    logic [7:0]          base_reg, base_next;
    logic [4:0]          outer_reg, outer_next;
    logic [lcbm_pkg::BANK_W-1:0] low_reg, high_reg;
    logic [lcbm_pkg::BANK_W-1:0] vlow_next, vhigh_next, vhigh_reg;
    logic                need_low_next, need_high_next, need_high_reg;
    lcbm_pkg::result_t   res_next, res_reg;
    logic                out_valid_reg;
    lcbm_pkg::result_t   out_res_reg;
    logic [lcbm_pkg::BANK_W-1:0] out_low_reg, out_high_reg;
    logic                out_free;
    logic                mod_start, mod_done;
    logic [lcbm_pkg::BANK_W-1:0] mod_value, mod_result;
    logic [lcbm_pkg::COUNT_W-1:0] divisor;

    function automatic logic [15:0] unscramble(input logic [15:0] a);
        logic [15:0] u;
        u = a & lcbm_pkg::UNSCR_KEEP;
        u[0] = a[6];
        u[1] = a[4];
        u[4] = a[1];
        u[6] = a[0];
        return u;
    endfunction

    assign divisor  = (cfg.rom_bank_count > MaxBanks) ? MaxBanks : cfg.rom_bank_count;
    assign out_free = !out_valid_reg || out_ready;

    lcbm_mod u_mod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .value   (mod_value),
        .divisor (divisor),
        .done    (mod_done),
        .result  (mod_result)
    );

    // Execute the current item against the lock and bank registers
    always_comb
    begin
        logic        engaged;
        logic [5:0]  cnt1;
        logic [15:0] a;
        logic [15:0] x;
        logic [7:0]  mh;
        logic [17:0] ram_mask;
        a              = cur_reg.addr;
        x              = a;
        engaged        = lock_reg != lcbm_pkg::LOCK_OPEN;
        cnt1           = hcnt_reg + 6'd1;
        ram_mask       = cfg.ram_bytes - 18'd1;
        lock_next      = lock_reg;
        hcnt_next      = hcnt_reg;
        mask_next      = mask_reg;
        unm_next       = unm_reg;
        base_next      = base_reg;
        outer_next     = outer_reg;
        vlow_next      = '0;
        vhigh_next     = '0;
        need_low_next  = 1'b0;
        need_high_next = 1'b0;
        mh             = '0;
        res_next.kind   = lcbm_pkg::KIND_NONE;
        res_next.target = '0;
        res_next.data   = '0;
        case (cur_reg.op)
            lcbm_pkg::OP_CART_RD:
            begin
                if (engaged && !cur_reg.boot_on)
                begin
                    lock_next = lcbm_pkg::LOCK_OPEN;
                    hcnt_next = '0;
                end
                else if (engaged && cur_reg.hdr_read)
                begin
                    if (cnt1 == lcbm_pkg::LOCK_STEP_CNT)
                    begin
                        lock_next = (lock_reg == lcbm_pkg::LOCK_FIRST) ?
                                    lcbm_pkg::LOCK_SECOND : lcbm_pkg::LOCK_OPEN;
                        hcnt_next = '0;
                    end
                    else
                    begin
                        hcnt_next = cnt1;
                    end
                end
                if (!a[15] && !a[14])
                begin
                    if ((lock_next != lcbm_pkg::LOCK_OPEN || cfg.scrambled_header) &&
                        cur_reg.hdr_window)
                    begin
                        if (lock_next == lcbm_pkg::LOCK_SECOND)
                        begin
                            x = x | lcbm_pkg::SECOND_BIT;
                        end
                        x = unscramble(x);
                    end
                    res_next.kind   = lcbm_pkg::KIND_ROM;
                    res_next.target = {low_reg, x[13:0]};
                end
                else if (!a[15])
                begin
                    res_next.kind   = lcbm_pkg::KIND_ROM;
                    res_next.target = {high_reg, a[13:0]};
                end
                else if (cur_reg.region == lcbm_pkg::RGN_A000)
                begin
                    if (cfg.ram_bytes != '0)
                    begin
                        res_next.kind   = lcbm_pkg::KIND_RAM_RD;
                        res_next.target = {10'd0, a[12:0] & ram_mask[12:0]};
                    end
                    else
                    begin
                        res_next.kind = lcbm_pkg::KIND_OPEN_BUS;
                    end
                end
                else
                begin
                    res_next.kind   = lcbm_pkg::KIND_PASS;
                    res_next.target = {7'd0, a};
                end
            end
            lcbm_pkg::OP_CART_WR:
            begin
                case (cur_reg.region)
                    lcbm_pkg::RGN_0000:
                    begin
                        if ((unm_reg & lcbm_pkg::CTRL_OPEN_BITS) == lcbm_pkg::CTRL_OPEN_BITS)
                        begin
                            base_next     = cur_reg.data;
                            vlow_next     = {4'd0, outer_reg} +
                                            {1'b0, cur_reg.data & mask_reg};
                            need_low_next = 1'b1;
                        end
                    end
                    lcbm_pkg::RGN_2000:
                    begin
                        if (cfg.alternate_wiring && ((a & lcbm_pkg::OUTER_SEL) ==
                                                     lcbm_pkg::OUTER_SEL))
                        begin
                            outer_next     = {cur_reg.data[0], 4'd0};
                            vlow_next      = {4'd0, outer_next};
                            vhigh_next     = {4'd0, outer_next} +
                                             {1'b0, (unm_reg == '0) ? 8'd1 : unm_reg};
                            need_low_next  = 1'b1;
                            need_high_next = 1'b1;
                        end
                        else
                        begin
                            unm_next       = (cur_reg.data == '0) ? 8'd1 : cur_reg.data;
                            mh             = (unm_next & ~mask_reg) | (base_reg & mask_reg);
                            vhigh_next     = {4'd0, outer_reg} + {1'b0, mh};
                            need_high_next = 1'b1;
                        end
                    end
                    lcbm_pkg::RGN_4000:
                    begin
                        if ((unm_reg & lcbm_pkg::CTRL_OPEN_BITS) == lcbm_pkg::CTRL_OPEN_BITS)
                        begin
                            mask_next      = cur_reg.data;
                            mh             = (unm_reg & ~mask_next) | (base_reg & mask_next);
                            vhigh_next     = {4'd0, outer_reg} + {1'b0, mh};
                            vlow_next      = {4'd0, outer_reg} +
                                             {1'b0, base_reg & mask_next};
                            need_low_next  = 1'b1;
                            need_high_next = 1'b1;
                        end
                    end
                    lcbm_pkg::RGN_6000:
                    begin
                        // ignore writes here
                    end
                    lcbm_pkg::RGN_A000:
                    begin
                        if (cfg.ram_bytes != '0)
                        begin
                            res_next.kind   = lcbm_pkg::KIND_RAM_WR;
                            res_next.target = {10'd0, a[12:0] & ram_mask[12:0]};
                            res_next.data   = cur_reg.data;
                        end
                    end
                    default:
                    begin
                        res_next.kind   = lcbm_pkg::KIND_PASS;
                        res_next.target = {7'd0, a};
                        res_next.data   = cur_reg.data;
                    end
                endcase
            end
            lcbm_pkg::OP_HIGH_RD:
            begin
                if (a[15] && a[14] && lock_reg == lcbm_pkg::LOCK_FIRST)
                begin
                    lock_next = lcbm_pkg::LOCK_SECOND;
                    hcnt_next = '0;
                end
            end
            default:
            begin
                if (cur_reg.region == lcbm_pkg::RGN_C000 && lock_reg == lcbm_pkg::LOCK_FIRST)
                begin
                    lock_next = lcbm_pkg::LOCK_SECOND;
                    hcnt_next = '0;
                end
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcbm_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = lcbm_pkg::BK_EXEC;
                end
            end
            lcbm_pkg::BK_EXEC:
            begin
                if (need_low_next)
                begin
                    state_next = lcbm_pkg::BK_RED_LOW;
                end
                else if (need_high_next)
                begin
                    state_next = lcbm_pkg::BK_RED_HIGH;
                end
                else
                begin
                    state_next = lcbm_pkg::BK_DONE;
                end
            end
            lcbm_pkg::BK_RED_LOW:
            begin
                if (mod_done)
                begin
                    state_next = need_high_reg ? lcbm_pkg::BK_RED_HIGH : lcbm_pkg::BK_DONE;
                end
            end
            lcbm_pkg::BK_RED_HIGH:
            begin
                if (mod_done)
                begin
                    state_next = lcbm_pkg::BK_DONE;
                end
            end
            lcbm_pkg::BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = lcbm_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lcbm_pkg::BK_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        q_pop     = 1'b0;
        mod_start = 1'b0;
        mod_value = vhigh_reg;
        case (state_reg)
            lcbm_pkg::BK_IDLE:
            begin
                q_pop = q_valid;
            end
            lcbm_pkg::BK_EXEC:
            begin
                mod_start = need_low_next || need_high_next;
                mod_value = need_low_next ? vlow_next : vhigh_next;
            end
            lcbm_pkg::BK_RED_LOW:
            begin
                mod_start = mod_done && need_high_reg;
            end
            default:
            begin
                mod_start = 1'b0;
            end
        endcase
    end

    // Hold the item and its pending result
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
        if (state_reg == lcbm_pkg::BK_EXEC)
        begin
            res_reg       <= res_next;
            vhigh_reg     <= vhigh_next;
            need_high_reg <= need_high_next;
        end
        if (state_reg == lcbm_pkg::BK_DONE && out_free)
        begin
            out_res_reg  <= res_reg;
            out_low_reg  <= low_reg;
            out_high_reg <= high_reg;
        end
    end

    // Update lock, bank registers and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcbm_pkg::BK_IDLE;
            lock_reg      <= lcbm_pkg::LOCK_FIRST;
            hcnt_reg      <= '0;
            mask_reg      <= '0;
            unm_reg       <= '0;
            base_reg      <= '0;
            outer_reg     <= '0;
            low_reg       <= '0;
            high_reg      <= 9'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lcbm_pkg::BK_EXEC)
            begin
                lock_reg  <= lock_next;
                hcnt_reg  <= hcnt_next;
                mask_reg  <= mask_next;
                unm_reg   <= unm_next;
                base_reg  <= base_next;
                outer_reg <= outer_next;
            end
            if (state_reg == lcbm_pkg::BK_RED_LOW && mod_done)
            begin
                low_reg <= mod_result;
            end
            if (state_reg == lcbm_pkg::BK_RED_HIGH && mod_done)
            begin
                high_reg <= mod_result;
            end
            if (state_reg == lcbm_pkg::BK_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign low_now   = out_low_reg;
    assign high_now  = out_high_reg;

endmodule

// ----- design/locked_cartridge_bank_mapper.sv -----
// Top level of the locked cartridge bank mapper with its register port.
`include "assert_macros.svh"

// Cartridge bank mapper: one bus access in, one result out. The front queue holds
// up to two items, so the input keeps flowing while a result waits. The back end
// serves one item at a time. A read, a notice or a non-bank write skips the
// shared remainder unit; a bank write that changes one bank number or both
// waits on it, as it reduces each bank number by the bank count, three quotient
// bits per cycle.
module locked_cartridge_bank_mapper
#(
    parameter int MAX_ROM_BANKS = lcbm_pkg::MAX_ROM_BANKS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [15:0] mem_address,
    input  logic [7:0]  write_data,
    input  logic        boot_register_on,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  access_kind,
    output logic [22:0] target_address,
    output logic [7:0]  out_data,
    output logic [8:0]  low_bank_now,
    output logic [8:0]  high_bank_now
);

    lcbm_pkg::cfg_t    cfg_reg;
    logic              boot_start_reg;
    logic              cfg_wr;
    logic              q_valid;
    logic              q_pop;
    lcbm_pkg::item_t   q_item;
    lcbm_pkg::result_t out_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rom_bank_count   <= 10'd2;
            cfg_reg.ram_bytes        <= '0;
            cfg_reg.scrambled_header <= 1'b0;
            cfg_reg.alternate_wiring <= 1'b0;
            boot_start_reg           <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                lcbm_pkg::REG_ROM_BANK_COUNT:    cfg_reg.rom_bank_count   <= pwdata[9:0];
                lcbm_pkg::REG_RAM_BYTES:         cfg_reg.ram_bytes        <= pwdata[17:0];
                lcbm_pkg::REG_SCRAMBLED_HEADER:  cfg_reg.scrambled_header <= pwdata[0];
                lcbm_pkg::REG_ALTERNATE_WIRING:  cfg_reg.alternate_wiring <= pwdata[0];
                lcbm_pkg::REG_BOOT_ROM_AT_START: boot_start_reg           <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        case (paddr[4:2])
            lcbm_pkg::REG_ROM_BANK_COUNT:    prdata = {22'd0, cfg_reg.rom_bank_count};
            lcbm_pkg::REG_RAM_BYTES:         prdata = {14'd0, cfg_reg.ram_bytes};
            lcbm_pkg::REG_SCRAMBLED_HEADER:  prdata = {31'd0, cfg_reg.scrambled_header};
            lcbm_pkg::REG_ALTERNATE_WIRING:  prdata = {31'd0, cfg_reg.alternate_wiring};
            lcbm_pkg::REG_BOOT_ROM_AT_START: prdata = {31'd0, boot_start_reg};
            default:                         prdata = '0;
        endcase
    end

    lcbm_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .mem_address      (mem_address),
        .write_data       (write_data),
        .boot_register_on (boot_register_on),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop)
    );

    lcbm_back #(.MAX_ROM_BANKS(MAX_ROM_BANKS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res),
        .low_now   (low_bank_now),
        .high_now  (high_bank_now)
    );

    assign access_kind    = out_res.kind;
    assign target_address = out_res.target;
    assign out_data       = out_res.data;

    // Result consistency checks
    `ASSERT_IMPL(a_no_target, clk, rst_n,
        out_valid && (access_kind == lcbm_pkg::KIND_OPEN_BUS ||
                      access_kind == lcbm_pkg::KIND_NONE),
        target_address == '0, "target set on open bus or empty result")
    `ASSERT_IMPL(a_no_data, clk, rst_n,
        out_valid && access_kind != lcbm_pkg::KIND_RAM_WR && access_kind != lcbm_pkg::KIND_PASS,
        out_data == '0, "write data on a result that writes nothing")
    `ASSERT_IMPL(a_ram_range, clk, rst_n,
        out_valid && (access_kind == lcbm_pkg::KIND_RAM_RD ||
                      access_kind == lcbm_pkg::KIND_RAM_WR),
        target_address[22:13] == '0, "RAM address outside the RAM window")

endmodule

// ----- verif/lcbm_checker.sv -----
// Scoreboard for the cartridge bank mapper: predicts each access result and compares.
module lcbm_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [15:0] mem_address,
    input  logic [7:0]  write_data,
    input  logic        boot_register_on,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  access_kind,
    input  logic [22:0] target_address,
    input  logic [7:0]  out_data,
    input  logic [8:0]  low_bank_now,
    input  logic [8:0]  high_bank_now,
    output int          fail_count,
    output int          pending,
    output int          served
);

    typedef struct packed {
        lcbm_pkg::kind_t kind;
        logic [22:0]     target;
        logic [7:0]      data;
        logic [8:0]      low;
        logic [8:0]      high;
    } access_res_t;

    // Shadow configuration
    logic [9:0]  bank_count;
    logic [17:0] ram_size;
    logic        scr_hdr;
    logic        alt_wire;
    logic        boot_start;

    // Shadow mapper state
    lcbm_pkg::lock_t lock;
    logic [5:0]  hdr_reads;
    logic [7:0]  mask_r;
    logic [7:0]  unmasked_r;
    logic [7:0]  base_r;
    logic [4:0]  outer_r;
    logic [8:0]  low_r;
    logic [8:0]  high_r;

    access_res_t expected_q[$];

    function automatic logic [8:0] reduce_bank(input int v);
        int c;
        c = (bank_count > 10'd512) ? 512 : int'(bank_count);
        if (c == 0)
            return 9'd0;
        return 9'(v % c);
    endfunction

    function automatic logic [15:0] descramble(input logic [15:0] a);
        logic [15:0] u;
        u = a & lcbm_pkg::UNSCR_KEEP;
        u[0] = u[0] | a[6];
        u[1] = u[1] | a[4];
        u[4] = u[4] | a[1];
        u[6] = u[6] | a[0];
        return u;
    endfunction

    function automatic logic [7:0] high_select(input logic [7:0] unm);
        return (unm & ~mask_r) | (base_r & mask_r);
    endfunction

    // Work out the result of one access and advance the shadow state
    function automatic access_res_t predict_access(input lcbm_pkg::op_t op,
                                                   input logic [15:0] a,
                                                   input logic [7:0] d, input logic boot);
        access_res_t r;
        logic [2:0]  rgn;
        logic [15:0] x;
        logic [17:0] ram_off;
        r.kind = lcbm_pkg::KIND_NONE;
        r.target = '0;
        r.data = '0;
        rgn = a[15:13];
        ram_off = 18'(a - 16'hA000) & (ram_size - 18'd1);
        case (op)
            lcbm_pkg::OP_CART_RD:
            begin
                if (lock != lcbm_pkg::LOCK_OPEN && !boot)
                begin
                    lock = lcbm_pkg::LOCK_OPEN;
                    hdr_reads = '0;
                end
                else if (lock != lcbm_pkg::LOCK_OPEN &&
                         (a & lcbm_pkg::HDR_READ_MASK) == lcbm_pkg::HDR_READ_MATCH)
                begin
                    hdr_reads = hdr_reads + 6'd1;
                    if (hdr_reads == lcbm_pkg::LOCK_STEP_CNT)
                    begin
                        lock = (lock == lcbm_pkg::LOCK_FIRST) ? lcbm_pkg::LOCK_SECOND :
                                                                lcbm_pkg::LOCK_OPEN;
                        hdr_reads = '0;
                    end
                end
                if (a < 16'h4000)
                begin
                    x = a;
                    if ((lock != lcbm_pkg::LOCK_OPEN || scr_hdr) &&
                        (x & lcbm_pkg::HDR_WIN_MASK) == lcbm_pkg::HDR_READ_MATCH)
                    begin
                        if (lock == lcbm_pkg::LOCK_SECOND)
                            x = x | lcbm_pkg::SECOND_BIT;
                        x = descramble(x);
                    end
                    r.kind = lcbm_pkg::KIND_ROM;
                    r.target = {low_r, 14'd0} + 23'(x);
                end
                else if (a < 16'h8000)
                begin
                    r.kind = lcbm_pkg::KIND_ROM;
                    r.target = {high_r, 14'd0} + 23'(a - 16'h4000);
                end
                else if (rgn == lcbm_pkg::RGN_A000)
                begin
                    if (ram_size != 0)
                    begin
                        r.kind = lcbm_pkg::KIND_RAM_RD;
                        r.target = 23'(ram_off);
                    end
                    else
                    begin
                        r.kind = lcbm_pkg::KIND_OPEN_BUS;
                    end
                end
                else
                begin
                    r.kind = lcbm_pkg::KIND_PASS;
                    r.target = 23'(a);
                end
            end
            lcbm_pkg::OP_CART_WR:
            begin
                if (rgn == lcbm_pkg::RGN_0000)
                begin
                    if ((unmasked_r & lcbm_pkg::CTRL_OPEN_BITS) == lcbm_pkg::CTRL_OPEN_BITS)
                    begin
                        base_r = d;
                        low_r = reduce_bank(int'(outer_r) + int'(base_r & mask_r));
                    end
                end
                else if (rgn == lcbm_pkg::RGN_2000)
                begin
                    if (alt_wire && (a & lcbm_pkg::OUTER_SEL) == lcbm_pkg::OUTER_SEL)
                    begin
                        outer_r = {d[0], 4'd0};
                        low_r = reduce_bank(int'(outer_r));
                        high_r = reduce_bank(int'(outer_r) +
                                             (unmasked_r == 0 ? 1 : int'(unmasked_r)));
                    end
                    else
                    begin
                        unmasked_r = (d == 0) ? 8'd1 : d;
                        high_r = reduce_bank(int'(outer_r) + int'(high_select(unmasked_r)));
                    end
                end
                else if (rgn == lcbm_pkg::RGN_4000)
                begin
                    if ((unmasked_r & lcbm_pkg::CTRL_OPEN_BITS) == lcbm_pkg::CTRL_OPEN_BITS)
                    begin
                        mask_r = d;
                        high_r = reduce_bank(int'(outer_r) + int'(high_select(unmasked_r)));
                        low_r = reduce_bank(int'(outer_r) + int'(base_r & mask_r));
                    end
                end
                else if (rgn == lcbm_pkg::RGN_6000)
                begin
                    // control range with no register behind it
                end
                else if (rgn == lcbm_pkg::RGN_A000)
                begin
                    if (ram_size != 0)
                    begin
                        r.kind = lcbm_pkg::KIND_RAM_WR;
                        r.target = 23'(ram_off);
                        r.data = d;
                    end
                end
                else
                begin
                    r.kind = lcbm_pkg::KIND_PASS;
                    r.target = 23'(a);
                    r.data = d;
                end
            end
            lcbm_pkg::OP_HIGH_RD:
            begin
                if (a >= 16'hC000 && lock == lcbm_pkg::LOCK_FIRST)
                begin
                    lock = lcbm_pkg::LOCK_SECOND;
                    hdr_reads = '0;
                end
            end
            default:
            begin
                if (rgn == lcbm_pkg::RGN_C000 && lock == lcbm_pkg::LOCK_FIRST)
                begin
                    lock = lcbm_pkg::LOCK_SECOND;
                    hdr_reads = '0;
                end
            end
        endcase
        r.low = low_r;
        r.high = high_r;
        return r;
    endfunction

    // Snoop register writes, predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin
        access_res_t exp_r;
        access_res_t got;
        int delta;
        if (!rst_n)
        begin
            bank_count = 10'd2;
            ram_size = '0;
            scr_hdr = 1'b0;
            alt_wire = 1'b0;
            boot_start = 1'b1;
            lock = lcbm_pkg::LOCK_FIRST;
            hdr_reads = '0;
            mask_r = '0;
            unmasked_r = '0;
            base_r = '0;
            outer_r = '0;
            low_r = 9'd0;
            high_r = 9'd1;
            expected_q.delete();
            fail_count <= 0;
            pending <= 0;
            served <= 0;
        end
        else
        begin
            delta = 0;
            if (psel && penable && pwrite && pready)
            begin
                case (3'(paddr >> 2))
                    lcbm_pkg::REG_ROM_BANK_COUNT:    bank_count = pwdata[9:0];
                    lcbm_pkg::REG_RAM_BYTES:         ram_size = pwdata[17:0];
                    lcbm_pkg::REG_SCRAMBLED_HEADER:  scr_hdr = pwdata[0];
                    lcbm_pkg::REG_ALTERNATE_WIRING:  alt_wire = pwdata[0];
                    lcbm_pkg::REG_BOOT_ROM_AT_START: boot_start = pwdata[0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = {lcbm_pkg::kind_t'(access_kind), target_address, out_data,
                       low_bank_now, high_bank_now};
                served <= served + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with no access pending, expected none, actual %h",
                             $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    delta = delta - 1;
                    if (got != exp_r)
                    begin
                        fail_count <= fail_count + 1;
                        if (got.kind != exp_r.kind)
                            $display("%0t: access_kind expected %0d actual %0d",
                                     $time, exp_r.kind, got.kind);
                        if (got.target != exp_r.target)
                            $display("%0t: target_address expected %h actual %h",
                                     $time, exp_r.target, got.target);
                        if (got.data != exp_r.data)
                            $display("%0t: out_data expected %h actual %h",
                                     $time, exp_r.data, got.data);
                        if (got.low != exp_r.low)
                            $display("%0t: low_bank_now expected %0d actual %0d",
                                     $time, exp_r.low, got.low);
                        if (got.high != exp_r.high)
                            $display("%0t: high_bank_now expected %0d actual %0d",
                                     $time, exp_r.high, got.high);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_q.push_back(predict_access(lcbm_pkg::op_t'(opcode), mem_address,
                                                    write_data, boot_register_on));
                delta = delta + 1;
            end
            pending <= pending + delta;
        end
    end

endmodule

// ----- verif/tb_locked_cartridge_bank_mapper.sv -----
// Stimulus and verdict for the cartridge bank mapper.
module tb_locked_cartridge_bank_mapper;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [15:0] mem_address;
    logic [7:0]  write_data;
    logic        boot_register_on;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  access_kind;
    logic [22:0] target_address;
    logic [7:0]  out_data;
    logic [8:0]  low_bank_now;
    logic [8:0]  high_bank_now;
    int          fail_count;
    int          pending;
    int          served;
    int          sent_items;
    int          cfg_writes;

    locked_cartridge_bank_mapper dut (.*);

    lcbm_checker scoreboard (.*);

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Drop the run if it hangs
    initial
    begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    // Drain results with random stalls, with quiet stretches now and then
    initial
    begin
        int stall;
        int calm;
        out_ready = 1'b0;
        calm = 0;
        @(posedge rst_n);
        forever
        begin
            if (calm > 0)
            begin
                calm--;
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 11);
                if ($urandom_range(0, 39) == 0)
                    calm = $urandom_range(10, 40);
            end
            repeat (stall)
            begin
                out_ready <= 1'b0;
                @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Send one item, holding it until accepted, then idle a random gap
    task automatic send_item(input lcbm_pkg::op_t op, input logic [15:0] a,
                             input logic [7:0] d, input logic boot, input bit no_gap);
        int gap;
        in_valid <= 1'b1;
        opcode <= op;
        mem_address <= a;
        write_data <= d;
        boot_register_on <= boot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
        gap = no_gap ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Register write in setup and access phases, then the bus returns to idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        in_valid <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_writes++;
        @(posedge clk);
    endtask

    // Hold off until every result is back and the block is quiet
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // One random access, weighted toward the cartridge ranges and bank control
    task automatic send_random(input int hdr_pct, input int boot_off_pct, input bit burst);
        lcbm_pkg::op_t op;
        logic [15:0]   a;
        logic [7:0]    d;
        int            pick;
        pick = $urandom_range(0, 99);
        d = 8'($urandom);
        if ($urandom_range(0, 1) == 1)
            d = d | lcbm_pkg::CTRL_OPEN_BITS;
        if (pick < hdr_pct)
        begin
            op = lcbm_pkg::OP_CART_RD;
            a = 16'h0100 | (16'($urandom) & 16'h78FF);
        end
        else
        begin
            op = lcbm_pkg::op_t'($urandom_range(0, 3));
            case ($urandom_range(0, 6))
                0: a = 16'($urandom_range(16'h0000, 16'h3FFF));
                1: a = 16'($urandom_range(16'h4000, 16'h7FFF));
                2: a = 16'($urandom_range(16'hA000, 16'hBFFF));
                3: a = 16'h2000 | lcbm_pkg::OUTER_SEL | (16'($urandom) & 16'h1F3F);
                4: a = 16'($urandom_range(16'hC000, 16'hFFFF));
                5: a = 16'h0100 | 16'($urandom_range(0, 255));
                default: a = 16'($urandom);
            endcase
        end
        send_item(op, a, d, $urandom_range(0, 99) >= boot_off_pct, burst);
    endtask

    initial
    begin
        bit burst;
        int phase;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        opcode = lcbm_pkg::OP_CART_RD;
        mem_address = '0;
        write_data = '0;
        boot_register_on = 1'b1;
        sent_items = 0;
        cfg_writes = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every operation, locked header reads, bank writes
        send_item(lcbm_pkg::OP_CART_RD, 16'h0000, 8'h00, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_CART_RD, 16'h0100, 8'h00, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_CART_RD, 16'h01FF, 8'h00, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_CART_RD, 16'h3FFF, 8'h00, 1'b1, 1'b1);
        send_item(lcbm_pkg::OP_CART_RD, 16'h4000, 8'h00, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_CART_RD, 16'h7FFF, 8'h00, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_CART_RD, 16'hA000, 8'h00, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_CART_WR, 16'hBFFF, 8'hFF, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_CART_RD, 16'hFFFF, 8'h00, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_CART_WR, 16'hFFFF, 8'hA5, 1'b1, 1'b1);
        send_item(lcbm_pkg::OP_CART_WR, 16'h2000, 8'h00, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_CART_WR, 16'h2000, 8'hFF, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_CART_WR, 16'h0000, 8'h5A, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_CART_WR, 16'h4000, 8'h0F, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_CART_WR, 16'h6000, 8'hFF, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_CART_WR, 16'h20C0, 8'h01, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_HIGH_WR, 16'hE000, 8'h11, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_HIGH_RD, 16'hBFFF, 8'h00, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_HIGH_WR, 16'hC000, 8'h22, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_CART_RD, 16'h0180, 8'h00, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_HIGH_RD, 16'hFFFF, 8'h00, 1'b1, 1'b0);
        send_item(lcbm_pkg::OP_CART_RD, 16'h8100, 8'h00, 1'b1, 1'b0);

        // Lock walk: many header reads with the boot register on, boot off at the end
        for (int i = 0; i < 200; i++)
            send_random(45, 0, 1'b0);
        send_item(lcbm_pkg::OP_CART_RD, 16'h0155, 8'h00, 1'b0, 1'b0);
        drain_results();

        // Configuration sweep, extremes included
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(lcbm_pkg::REG_ROM_BANK_COUNT, 32'd1);
                    write_reg(lcbm_pkg::REG_RAM_BYTES, 32'd131072);
                    write_reg(lcbm_pkg::REG_SCRAMBLED_HEADER, 32'd1);
                    write_reg(lcbm_pkg::REG_ALTERNATE_WIRING, 32'd1);
                    write_reg(lcbm_pkg::REG_BOOT_ROM_AT_START, 32'd0);
                end
                1:
                begin
                    write_reg(lcbm_pkg::REG_ROM_BANK_COUNT, 32'd512);
                    write_reg(lcbm_pkg::REG_RAM_BYTES, 32'd3);
                    write_reg(lcbm_pkg::REG_SCRAMBLED_HEADER, 32'd0);
                end
                2:
                begin
                    write_reg(lcbm_pkg::REG_ROM_BANK_COUNT, 32'd1023);
                    write_reg(lcbm_pkg::REG_RAM_BYTES, 32'h3FFFF);
                    write_reg(lcbm_pkg::REG_BOOT_ROM_AT_START, 32'd1);
                end
                3:
                begin
                    write_reg(lcbm_pkg::REG_ROM_BANK_COUNT, 32'd0);
                    write_reg(lcbm_pkg::REG_RAM_BYTES, 32'd0);
                    write_reg(lcbm_pkg::REG_ALTERNATE_WIRING, 32'd0);
                end
                4:
                begin
                    write_reg(lcbm_pkg::REG_ROM_BANK_COUNT, 32'd7);
                    write_reg(lcbm_pkg::REG_RAM_BYTES, 32'd8192);
                    write_reg(lcbm_pkg::REG_SCRAMBLED_HEADER, 32'd1);
                end
                default:
                begin
                    write_reg(lcbm_pkg::REG_ROM_BANK_COUNT, 32'd100);
                    write_reg(lcbm_pkg::REG_RAM_BYTES, 32'd1);
                    write_reg(lcbm_pkg::REG_ALTERNATE_WIRING, 32'd1);
                end
            endcase
            for (int i = 0; i < 55; i++)
            begin
                burst = (phase % 2 == 1) && (i < 20);
                send_random(15, 30, burst);
            end
            drain_results();
        end

        repeat (30) @(posedge clk);
        $display("tb: %0d accesses sent, %0d results checked, %0d register writes",
                 sent_items, served, cfg_writes);
        $display("tb: covered lock walk, boot-off unlock and six bank/RAM settings");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
